>>> src/unsp_instruction_predecoder_core_macros.svh
// assertion macros for the instruction predecoder
`ifndef UNSP_INSTRUCTION_PREDECODER_CORE_MACROS_SVH
`define UNSP_INSTRUCTION_PREDECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define UNSP_PD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("predecoder assertion failed");

// next-cycle implication, disabled while reset is low
`define UNSP_PD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("predecoder sequencing assertion failed");

`else

`define UNSP_PD_ASSERT(lbl, clk, rst_n, prop)
`define UNSP_PD_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

>>> src/unsp_pd_pkg.sv
package unsp_pd_pkg;

  // register indices in the read and write masks
  localparam logic [2:0] REG_SP = 3'd0;
  localparam logic [2:0] REG_R3 = 3'd3;
  localparam logic [2:0] REG_R4 = 3'd4;
  localparam logic [2:0] REG_BP = 3'd5;
  localparam logic [2:0] REG_SR = 3'd6;
  localparam logic [2:0] REG_PC = 3'd7;

  // special encodings
  localparam logic [15:0] OP_RETI    = 16'h9a98;
  localparam logic [6:0]  LOWER_PUSH = 7'h2d;
  localparam logic [6:0]  LOWER_POP  = 7'h29;
  localparam logic [5:0]  IRQ_EXTRA  = 6'd37;

  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_COND   = 2'd1,
    BR_UNCOND = 2'd2
  } branch_kind_e;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_STATIC  = 2'd1,
    TGT_DYNAMIC = 2'd2
  } target_kind_e;

  typedef struct packed {
    logic [21:0] fetch_address;
    logic [15:0] instruction_word;
    logic [15:0] extension_word;
  } in_beat_t;

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  length_words;
    logic [4:0]  base_cycles;
    logic [7:0]  reads_regs;
    logic [7:0]  writes_regs;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  branch_kind;
    logic        ends_sequence;
    logic [1:0]  target_kind;
    logic [21:0] target_address;
  } out_beat_t;

  // one-hot mask bit of a register index
  function automatic logic [7:0] reg_bit(input logic [2:0] r);
    return 8'b1 << r;
  endfunction

endpackage

>>> src/unsp_instruction_predecoder_core.sv
// Instruction predecoder: takes one beat per clock unless stalled (fetch address, opcode
// word and the word after it) and returns one decode result per beat, in order. Each beat
// is held in an input register, decoded by a single combinational stage and captured in
// the result register, from which the result is offered. The sustained rate is one beat
// per cycle unless stalled, set by that one decode stage. out_stall_i backs up through
// both registers; with the output free the input is never stalled.
`include "unsp_instruction_predecoder_core_macros.svh"

module unsp_instruction_predecoder_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  unsp_pd_pkg::in_beat_t  in_beat_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output unsp_pd_pkg::out_beat_t out_beat_o
);

  logic                   s1_valid_q, s1_valid_d;
  unsp_pd_pkg::in_beat_t  s1_beat_q;
  logic                   out_valid_q, out_valid_d;
  unsp_pd_pkg::out_beat_t out_beat_q;
  unsp_pd_pkg::out_beat_t dec_res;
  logic                   out_adv;
  logic                   s1_adv;

  // pipeline advance
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;

  always_comb begin
    s1_valid_d  = s1_adv ? in_valid_i : s1_valid_q;
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_adv) begin
      s1_beat_q <= in_beat_i;
    end
    if (s1_valid_q && out_adv) begin
      out_beat_q <= dec_res;
    end
  end

  // decode stage
  unsp_pd_decode u_decode (
    .beat_i (s1_beat_q),
    .res_o  (dec_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // a held input beat is not dropped while the output is blocked
  `UNSP_PD_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !out_adv, s1_valid_q)

  // rejected encodings carry no effects
  `UNSP_PD_ASSERT(a_invalid_clean, clk_i, rst_ni,
    out_valid_q && !out_beat_q.valid_res |-> out_beat_q.length_words == 2'd1
      && out_beat_q.reads_regs == 8'd0 && out_beat_q.writes_regs == 8'd0
      && out_beat_q.target_address == 22'd0 && out_beat_q.base_cycles == 5'd0)

  // a static target always comes with an unconditional, sequence-ending branch
  `UNSP_PD_ASSERT(a_static_target, clk_i, rst_ni,
    out_valid_q && out_beat_q.target_kind == unsp_pd_pkg::TGT_STATIC
      |-> out_beat_q.branch_kind == unsp_pd_pkg::BR_UNCOND && out_beat_q.ends_sequence)

  // two-word forms are only reported for recognized encodings
  `UNSP_PD_ASSERT(a_len_two_valid, clk_i, rst_ni,
    out_valid_q && out_beat_q.length_words == 2'd2 |-> out_beat_q.valid_res)

endmodule

>>> src/unsp_pd_decode.sv
module unsp_pd_decode (
  input  unsp_pd_pkg::in_beat_t  beat_i,
  output unsp_pd_pkg::out_beat_t res_o
);

  // primary opcode groups
  localparam logic [3:0] OP0_RSVD5 = 4'd5;
  localparam logic [3:0] OP0_RSVD7 = 4'd7;
  localparam logic [3:0] OP0_CMP   = 4'd4;
  localparam logic [3:0] OP0_TEST  = 4'd12;
  localparam logic [3:0] OP0_STORE = 4'd13;
  localparam logic [3:0] OP0_JMP   = 4'd14;
  localparam logic [3:0] OP0_EXT   = 4'd15;

  // addressing modes of the alu forms
  localparam logic [2:0] MODE_BP_IMM6 = 3'd0;
  localparam logic [2:0] MODE_IMM6    = 3'd1;
  localparam logic [2:0] MODE_DS_IND  = 3'd3;
  localparam logic [2:0] MODE_REG     = 3'd4;
  localparam logic [2:0] MODE_SHIFT_A = 3'd5;
  localparam logic [2:0] MODE_SHIFT_B = 3'd6;
  localparam logic [2:0] MODE_DIRECT6 = 3'd7;

  // secondary codes of the extended group
  localparam logic [2:0] FX_MUL_A  = 3'd0;
  localparam logic [2:0] FX_CALL   = 3'd1;
  localparam logic [2:0] FX_JMPF   = 3'd2;
  localparam logic [2:0] FX_MUL_B  = 3'd4;
  localparam logic [2:0] FX_IRQ    = 3'd5;
  localparam logic [2:0] FX_MULS_A = 3'd6;
  localparam logic [2:0] FX_MULS_B = 3'd7;

  logic [3:0]  op0;
  logic [2:0]  opa, op1, opn, opb;
  logic [5:0]  imm6;
  logic [6:0]  lower;
  logic [21:0] pc;
  logic [4:0]  walk_cyc;
  logic [7:0]  push_rd, pop_wr;
  logic        pop_pc;
  logic        ok;
  logic        alu_tail;
  unsp_pd_pkg::out_beat_t d;

  // opcode fields
  assign op0   = beat_i.instruction_word[15:12];
  assign opa   = beat_i.instruction_word[11:9];
  assign op1   = beat_i.instruction_word[8:6];
  assign opn   = beat_i.instruction_word[5:3];
  assign opb   = beat_i.instruction_word[2:0];
  assign imm6  = beat_i.instruction_word[5:0];
  assign lower = {op1, op0};
  assign pc    = beat_i.fetch_address;

  // push and pop cost rises with each walked register
  assign walk_cyc = 5'd4 + {1'b0, opn, 1'b0};

  // register walks: push goes down from A, pop goes up past A
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      push_rd[r] = (3'(r) <= opa) && ((opa - 3'(r)) < opn);
      pop_wr[r]  = (3'(r) > opa) && ((3'(r) - opa) <= opn);
    end
  end
  assign pop_pc = (opa != unsp_pd_pkg::REG_PC) && ((unsp_pd_pkg::REG_PC - opa) <= opn);

  // main decode
  always_comb begin
    d = '0;
    d.length_words = 2'd1;
    ok = 1'b0;
    alu_tail = 1'b0;

    if (op0 != OP0_EXT && opa == unsp_pd_pkg::REG_PC && !op1[2] && !op1[1]) begin
      // relative and conditional jumps
      ok = 1'b1;
      d.base_cycles   = 5'd2;
      d.writes_regs   = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR)
                      | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC);
      d.ends_sequence = 1'b1;
      if (op0 == OP0_JMP) begin
        d.branch_kind = unsp_pd_pkg::BR_UNCOND;
        d.target_kind = unsp_pd_pkg::TGT_STATIC;
        if (op1 == 3'd0) begin
          d.target_address = pc + 22'd1 + {16'b0, imm6};
        end else begin
          d.target_address = pc + 22'd1 - {16'b0, imm6};
        end
      end else begin
        d.reads_regs  = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR);
        d.branch_kind = unsp_pd_pkg::BR_COND;
        d.target_kind = unsp_pd_pkg::TGT_DYNAMIC;
      end
    end else if (lower == unsp_pd_pkg::LOWER_PUSH) begin
      ok = 1'b1;
      d.base_cycles = walk_cyc;
      d.reads_regs  = unsp_pd_pkg::reg_bit(opb) | push_rd;
      d.writes_regs = unsp_pd_pkg::reg_bit(opb);
      d.mem_write   = 1'b1;
    end else if (lower == unsp_pd_pkg::LOWER_POP) begin
      ok = 1'b1;
      d.mem_read = 1'b1;
      if (beat_i.instruction_word == unsp_pd_pkg::OP_RETI) begin
        d.base_cycles   = 5'd8;
        d.reads_regs    = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SP);
        d.writes_regs   = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SP)
                        | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR)
                        | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC);
        d.branch_kind   = unsp_pd_pkg::BR_UNCOND;
        d.ends_sequence = 1'b1;
        d.target_kind   = unsp_pd_pkg::TGT_DYNAMIC;
      end else begin
        d.base_cycles = walk_cyc;
        d.reads_regs  = unsp_pd_pkg::reg_bit(opb);
        d.writes_regs = unsp_pd_pkg::reg_bit(opb) | pop_wr;
        if (pop_pc) begin
          d.branch_kind   = unsp_pd_pkg::BR_UNCOND;
          d.ends_sequence = 1'b1;
          d.target_kind   = unsp_pd_pkg::TGT_DYNAMIC;
        end
      end
    end else if (op0 == OP0_EXT) begin
      // extended group: multiplies, far call and jump, interrupt control
      case (op1)
        FX_MUL_A, FX_MUL_B: begin
          ok = (opn == 3'd1) && (opa != unsp_pd_pkg::REG_PC);
          d.base_cycles = 5'd12;
          d.reads_regs  = unsp_pd_pkg::reg_bit(opa) | unsp_pd_pkg::reg_bit(opb);
          d.writes_regs = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_R3)
                        | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_R4);
        end
        FX_CALL: begin
          ok = !opa[0];
          d.base_cycles    = 5'd9;
          d.length_words   = 2'd2;
          d.target_kind    = unsp_pd_pkg::TGT_STATIC;
          d.target_address = {imm6, beat_i.extension_word};
          d.branch_kind    = unsp_pd_pkg::BR_UNCOND;
          d.ends_sequence  = 1'b1;
          d.mem_read       = 1'b1;
          d.mem_write      = 1'b1;
          d.reads_regs     = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC)
                           | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SP);
          d.writes_regs    = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SP)
                           | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR)
                           | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC);
        end
        FX_JMPF: begin
          ok = (opa == unsp_pd_pkg::REG_PC);
          d.base_cycles    = 5'd5;
          d.length_words   = 2'd2;
          d.target_kind    = unsp_pd_pkg::TGT_STATIC;
          d.target_address = {imm6, beat_i.extension_word};
          d.branch_kind    = unsp_pd_pkg::BR_UNCOND;
          d.ends_sequence  = 1'b1;
          d.mem_read       = 1'b1;
          d.reads_regs     = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC);
          d.writes_regs    = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR)
                           | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC);
        end
        FX_IRQ: begin
          ok = (imm6 <= 6'd5) || (imm6 == 6'd8) || (imm6 == 6'd9) || (imm6 == 6'd12)
            || (imm6 == 6'd14) || (imm6 == unsp_pd_pkg::IRQ_EXTRA);
          d.base_cycles = 5'd2;
        end
        FX_MULS_A, FX_MULS_B: begin
          ok = 1'b1;
          d.reads_regs  = unsp_pd_pkg::reg_bit(opa) | unsp_pd_pkg::reg_bit(opb);
          d.writes_regs = unsp_pd_pkg::reg_bit(opa) | unsp_pd_pkg::reg_bit(opb)
                        | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_R3)
                        | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_R4);
          d.mem_read    = 1'b1;
          d.mem_write   = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end else begin
      // alu forms: operand fetch by addressing mode
      ok = 1'b1;
      d.reads_regs = unsp_pd_pkg::reg_bit(opa);
      case (op1)
        MODE_BP_IMM6: begin
          d.base_cycles = 5'd6;
          d.reads_regs  = d.reads_regs | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_BP);
          d.mem_read    = (op0 != OP0_STORE);
        end
        MODE_IMM6: begin
          d.base_cycles = 5'd2;
        end
        MODE_DS_IND: begin
          d.base_cycles = (opa == unsp_pd_pkg::REG_PC) ? 5'd7 : 5'd6;
          d.reads_regs  = d.reads_regs | unsp_pd_pkg::reg_bit(opb);
          if (opn[2]) begin
            d.reads_regs = d.reads_regs | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR);
          end
          if (opn[1:0] != 2'd0) begin
            d.writes_regs = unsp_pd_pkg::reg_bit(opb);
            if (opn[2]) begin
              d.writes_regs = d.writes_regs | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR);
            end
          end
          d.mem_read = (op0 != OP0_STORE);
        end
        MODE_REG: begin
          d.reads_regs = d.reads_regs | unsp_pd_pkg::reg_bit(opb);
          if (opn == 3'd1 || opn == 3'd2 || opn == 3'd3) begin
            if (opn == 3'd1) begin
              d.base_cycles = (opa == unsp_pd_pkg::REG_PC) ? 5'd5 : 5'd4;
            end else begin
              d.base_cycles = (opa == unsp_pd_pkg::REG_PC) ? 5'd8 : 5'd7;
            end
            d.length_words = 2'd2;
            d.reads_regs   = d.reads_regs | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR)
                           | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC);
            d.writes_regs  = unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR)
                           | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_PC);
            d.mem_read     = 1'b1;
          end else begin
            d.base_cycles = (opa == unsp_pd_pkg::REG_PC) ? 5'd5 : 5'd3;
          end
        end
        MODE_SHIFT_A, MODE_SHIFT_B: begin
          d.base_cycles = (opa == unsp_pd_pkg::REG_PC) ? 5'd5 : 5'd3;
          d.reads_regs  = d.reads_regs | unsp_pd_pkg::reg_bit(opb);
        end
        MODE_DIRECT6: begin
          d.base_cycles = (opa == unsp_pd_pkg::REG_PC) ? 5'd6 : 5'd5;
          d.mem_read    = 1'b1;
        end
        default: begin
          // stack-group leftovers: only the A register read
          d.base_cycles = 5'd0;
        end
      endcase

      // flag and store effects of the primary opcode
      case (op0)
        OP0_CMP, OP0_TEST: begin
          d.writes_regs = d.writes_regs | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR);
        end
        OP0_STORE: begin
          d.mem_write = 1'b1;
        end
        OP0_RSVD5, OP0_RSVD7, OP0_JMP: begin
          alu_tail = 1'b1;
        end
        default: begin
          d.writes_regs = d.writes_regs | unsp_pd_pkg::reg_bit(unsp_pd_pkg::REG_SR);
          alu_tail = 1'b1;
        end
      endcase

      // destination: memory for the indirect store mode, else register A
      if (alu_tail) begin
        if (op1 == MODE_REG && opn == 3'd3) begin
          d.mem_write = 1'b1;
        end else begin
          d.writes_regs = d.writes_regs | unsp_pd_pkg::reg_bit(opa);
          if (opa == unsp_pd_pkg::REG_PC) begin
            d.target_kind   = unsp_pd_pkg::TGT_DYNAMIC;
            d.branch_kind   = unsp_pd_pkg::BR_UNCOND;
            d.ends_sequence = 1'b1;
          end
        end
      end
    end

    // unrecognized encodings report only a one-word length
    if (!ok) begin
      d = '0;
      d.length_words = 2'd1;
    end
    d.valid_res = ok;
  end

  assign res_o = d;

endmodule
